### sv/itrs_pkg.sv
package itrs_pkg;

   // ASCII characters used in the text.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_QUEST = 8'h3F;

   // Accepted range of the base.
   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;

   // Longest text before the terminator.
   localparam logic [5:0] TEXT_LIMIT = 6'd63;

   // Quotient bits resolved per cycle by the divider.
   localparam int STEP_BITS = 8;

   // Classification of one item, passed from the front to the back.
   typedef struct packed {
      logic       bad;
      logic       neg;
      logic [5:0] width;
      logic [4:0] radix;
   } cls_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SETUP,
      ST_EMIT,
      ST_ERR_Q,
      ST_ERR_END
   } back_state_type;

   // Uppercase ASCII for one digit.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      digit_char = (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h37 + 8'(d));
   endfunction

endpackage

### sv/itrs_front.sv
module itrs_front import itrs_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_WIDTH  = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_is_signed,
   input  logic [4:0]            req_radix,
   input  logic [5:0]            req_min_width,
   output logic                  q_valid,
   output cls_type               q_cls,
   output logic [VALUE_BITS-1:0] q_mag,
   input  logic                  q_pop
);

   localparam logic [5:0] WIDTH_CAP = 6'(MAX_WIDTH);

   cls_type               cls;
   logic [VALUE_BITS-1:0] mag;
   logic                  push;

   cls_type               ent_cls_ff [2];
   logic [VALUE_BITS-1:0] ent_mag_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;

   // Classify the incoming item: base check, sign, magnitude, width limits.
   always_comb begin
      cls.bad   = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
      cls.neg   = req_is_signed & req_value[VALUE_BITS-1];
      cls.radix = req_radix;
      if (req_min_width == 6'd0) begin
         cls.width = 6'd1;
      end else if (req_min_width > WIDTH_CAP) begin
         cls.width = WIDTH_CAP;
      end else begin
         cls.width = req_min_width;
      end
      mag = cls.neg ? ((~req_value) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;
   end

   // Two-entry queue between the front and the back.
   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_cls     = ent_cls_ff[rd_ptr_ff];
   assign q_mag     = ent_mag_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_cls_ff[wr_ptr_ff] <= cls;
         ent_mag_ff[wr_ptr_ff] <= mag;
      end
   end

endmodule

### sv/itrs_back.sv
module itrs_back import itrs_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  cls_type               q_cls,
   input  logic [VALUE_BITS-1:0] q_mag,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_ch,
   output logic                  rsp_last,
   output logic                  rsp_bad_radix
);

   localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int WORK_BITS  = DIV_CYCLES * STEP_BITS;
   localparam int PHASE_W    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int IDX_W      = $clog2(VALUE_BITS);

   back_state_type          state_ff, state_in;
   cls_type                 cls_ff, cls_in;
   logic [WORK_BITS-1:0]    work_ff, work_in;
   logic [3:0]              rem_ff, rem_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [5:0]              pad_ff, pad_in;
   logic                    sign_ff, sign_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [3:0]              rd_data_ff;
   logic [5:0]              n_ff, n_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_ch_ff, rsp_ch_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic [3:0]              store_mem [VALUE_BITS];
   logic                    wr_en;

   logic [STEP_BITS-1:0]    q_bits;
   logic [3:0]              step_rem;
   logic [4:0]              trial;
   logic [WORK_BITS-1:0]    next_work;
   logic [6:0]              len7;
   logic [6:0]              width7;
   logic                    out_free;
   logic                    end_now;

   // Restoring division of the top byte of the work word by the base.
   always_comb begin
      step_rem = rem_ff;
      trial    = 5'd0;
      q_bits   = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {step_rem, work_ff[WORK_BITS-1-i]};
         if (trial >= cls_ff.radix) begin
            q_bits[STEP_BITS-1-i] = 1'b1;
            trial = trial - cls_ff.radix;
         end
         step_rem = trial[3:0];
      end
      next_work = (work_ff << STEP_BITS) | WORK_BITS'(q_bits);
   end

   assign len7     = 7'(count_ff) + 7'(cls_ff.neg);
   assign width7   = 7'(cls_ff.width);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign end_now  = (n_ff == TEXT_LIMIT) ||
                     (!sign_ff && (pad_ff == 6'd0) && (left_ff == '0));

   // Sequencer: take an item, divide digit by digit, emit text or error.
   always_comb begin
      state_in     = state_ff;
      cls_in       = cls_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      pad_in       = pad_ff;
      sign_in      = sign_ff;
      left_in      = left_ff;
      rd_idx_in    = rd_idx_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cls_in   = q_cls;
               work_in  = WORK_BITS'(q_mag);
               rem_in   = 4'd0;
               phase_in = '0;
               count_in = '0;
               if (q_cls.bad) begin
                  state_in = ST_ERR_Q;
               end else if (q_mag == '0) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            work_in = next_work;
            if (phase_ff == PHASE_W'(DIV_CYCLES - 1)) begin
               // One digit is complete: store it and restart the remainder.
               wr_en    = 1'b1;
               rem_in   = 4'd0;
               phase_in = '0;
               count_in = count_ff + 1'b1;
               if ((next_work == '0) || (count_in == CNT_W'(VALUE_BITS))) begin
                  state_in = ST_SETUP;
               end
            end else begin
               rem_in   = step_rem;
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_SETUP: begin
            // Work out sign and zero fill; start reading the top digit.
            sign_in   = cls_ff.neg;
            pad_in    = (width7 > len7) ? 6'(width7 - len7) : 6'd0;
            left_in   = count_ff;
            rd_idx_in = IDX_W'(count_ff - 1'b1);
            n_in      = 6'd0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = 1'b0;
               rsp_last_in  = 1'b0;
               n_in         = n_ff + 1'b1;
               if (end_now) begin
                  rsp_ch_in   = CH_NUL;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else if (sign_ff) begin
                  rsp_ch_in = CH_MINUS;
                  sign_in   = 1'b0;
               end else if (pad_ff != 6'd0) begin
                  rsp_ch_in = CH_ZERO;
                  pad_in    = pad_ff - 1'b1;
               end else begin
                  rsp_ch_in = digit_char(rd_data_ff);
                  left_in   = left_ff - 1'b1;
                  if (left_ff > CNT_W'(1)) begin
                     rd_idx_in = rd_idx_ff - 1'b1;
                  end
               end
            end
         end
         ST_ERR_Q: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_QUEST;
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b1;
               state_in     = ST_ERR_END;
            end
         end
         ST_ERR_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_NUL;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cls_ff      <= cls_in;
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      phase_ff    <= phase_in;
      count_ff    <= count_in;
      pad_ff      <= pad_in;
      sign_ff     <= sign_in;
      left_ff     <= left_in;
      rd_idx_ff   <= rd_idx_in;
      n_ff        <= n_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // Digit memory, least significant digit first, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[IDX_W-1:0]] <= step_rem;
      end
      rd_data_ff <= store_mem[rd_idx_in];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ch        = rsp_ch_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

endmodule

### sv/integer_to_radix_string.sv
// Converts an integer to its ASCII text in a base from 2 to 16.
// The request channel (req_) takes a value, a signed flag, a base and a
// minimum width. The response channel (rsp_) returns one character per item,
// most significant digit first, with an optional leading minus and zero fill,
// then a NUL with rsp_last set. A bad base gives "?" and NUL, both flagged.
// A two-entry queue decouples the classifying front from the back end, so a
// new request is taken while the previous one is still being converted.
// Sequence: the back end picks up an item, divides it digit by digit in its
// byte-serial divider (skipped for a zero value), passes a setup state, then
// emits the characters one at a time, the NUL included, waiting while
// rsp_ready is low. The shared back end takes no new item until it has sent
// the NUL of the current one; meanwhile the queue holds up to two items.
// Reset is synchronous and active high; it empties the queue and the output
// register and returns the sequencer to idle.
// When the receiver holds rsp_ready low, the current character stays on the
// port and the back end waits; the queue keeps accepting until it is full.
module integer_to_radix_string import itrs_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_WIDTH  = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_is_signed,
   input  logic [4:0]            req_radix,
   input  logic [5:0]            req_min_width,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_ch,
   output logic                  rsp_last,
   output logic                  rsp_bad_radix
);

   logic                  q_valid;
   cls_type               q_cls;
   logic [VALUE_BITS-1:0] q_mag;
   logic                  q_pop;

   // Front: classify and queue.
   itrs_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_radix     (req_radix),
      .req_min_width (req_min_width),
      .q_valid       (q_valid),
      .q_cls         (q_cls),
      .q_mag         (q_mag),
      .q_pop         (q_pop)
   );

   // Back: divide and emit.
   itrs_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cls         (q_cls),
      .q_mag         (q_mag),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ch        (rsp_ch),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

endmodule

### tb/sv/tb_integer_to_radix_string.sv
module tb_integer_to_radix_string;
   timeunit 1ns;
   timeprecision 1ps;

   import itrs_pkg::*;

   localparam int VALUE_BITS    = 32;
   localparam int RANDOM_ITEMS  = 189;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 300;

   localparam logic [7:0] CH_LETTER_A = 8'h41;

   // One conversion request as presented on the req_ ports.
   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic                  is_signed;
      logic [4:0]            radix;
      logic [5:0]            min_width;
   } conv_req_type;

   // One character of the text as it should appear on the rsp_ ports.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       bad;
   } text_char_type;

   // Families of values used by the random part.
   typedef enum logic [2:0] {
      SHAPE_WIDE,
      SHAPE_TINY,
      SHAPE_NEAR_TOP,
      SHAPE_NEAR_SIGN,
      SHAPE_ZERO
   } value_shape_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value     = '0;
   logic                  req_is_signed = 1'b0;
   logic [4:0]            req_radix     = '0;
   logic [5:0]            req_min_width = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [7:0]            rsp_ch;
   logic                  rsp_last;
   logic                  rsp_bad_radix;

   conv_req_type  conv_backlog[$];
   text_char_type text_due[$];

   // Private copy of the converter's digit state.
   logic [3:0]            digit_buf [VALUE_BITS];
   logic [5:0]            digit_tally = '0;
   logic [VALUE_BITS-1:0] running_quo = '0;

   conv_req_type on_wire;
   logic         offering;
   int           send_gap     = 0;
   int           send_calm    = 0;
   int           recv_gap     = 0;
   int           recv_calm    = 0;
   int           items_taken  = 0;
   int           fault_count  = 0;
   int unsigned  cycles_run   = 0;

   integer_to_radix_string #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_WIDTH (63)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_is_signed(req_is_signed),
      .req_radix    (req_radix),
      .req_min_width(req_min_width),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ch       (rsp_ch),
      .rsp_last     (rsp_last),
      .rsp_bad_radix(rsp_bad_radix)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
   end

   // Uppercase ASCII for one digit value.
   function automatic logic [7:0] glyph(input logic [3:0] d);
      return (d < 4'd10) ? CH_ZERO + 8'(d) : CH_LETTER_A + 8'(d) - 8'd10;
   endfunction

   function automatic text_char_type make_char(input logic [7:0] ch, input logic last,
                                               input logic bad);
      text_char_type c;
      c.ch   = ch;
      c.last = last;
      c.bad  = bad;
      return c;
   endfunction

   // Works out the full text of one request and queues each character.
   task automatic spell_number(input conv_req_type rq);
      logic [VALUE_BITS-1:0] mag;
      logic                  minus;
      int                    span;
      int                    fill;
      int                    sent;
      int                    k;
      if (rq.radix < RADIX_MIN || rq.radix > RADIX_MAX) begin
         text_due.push_back(make_char(CH_QUEST, 1'b0, 1'b1));
         text_due.push_back(make_char(CH_NUL, 1'b1, 1'b1));
         return;
      end
      // A 6-bit width never exceeds the saturation point, so only zero needs care.
      span  = (rq.min_width == 6'd0) ? 1 : int'(rq.min_width);
      minus = rq.is_signed && rq.value[VALUE_BITS-1];
      mag   = minus ? (~rq.value + 1'b1) : rq.value;

      // Digits are collected least significant first.
      running_quo = mag;
      digit_tally = '0;
      while (running_quo != '0 && digit_tally < VALUE_BITS) begin
         digit_buf[digit_tally[4:0]] = 4'(running_quo % rq.radix);
         running_quo = running_quo / rq.radix;
         digit_tally++;
      end

      fill = (int'(minus) + int'(digit_tally) < span) ?
             span - int'(minus) - int'(digit_tally) : 0;
      sent = 0;
      if (minus) begin
         text_due.push_back(make_char(CH_MINUS, 1'b0, 1'b0));
         sent++;
      end
      for (k = 0; k < fill && sent < int'(TEXT_LIMIT); k++) begin
         text_due.push_back(make_char(CH_ZERO, 1'b0, 1'b0));
         sent++;
      end
      for (k = int'(digit_tally); k > 0 && sent < int'(TEXT_LIMIT); k--) begin
         text_due.push_back(make_char(glyph(digit_buf[5'(k-1)]), 1'b0, 1'b0));
         sent++;
      end
      text_due.push_back(make_char(CH_NUL, 1'b1, 1'b0));
   endtask

   // Number of idle cycles before the next item, with occasional runs of none.
   function automatic int draw_pause(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(5, 20);
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic queue_request(input logic [VALUE_BITS-1:0] value, input logic is_signed,
                                input logic [4:0] radix, input logic [5:0] min_width);
      conv_req_type rq;
      rq.value     = value;
      rq.is_signed = is_signed;
      rq.radix     = radix;
      rq.min_width = min_width;
      conv_backlog.push_back(rq);
   endtask

   // Random request: mostly valid bases, mostly short widths, varied values.
   function automatic conv_req_type random_request();
      conv_req_type    rq;
      value_shape_type shape;
      int              pick;
      shape = value_shape_type'($urandom_range(0, 4));
      case (shape)
         SHAPE_WIDE:      rq.value = $urandom;
         SHAPE_TINY:      rq.value = $urandom_range(0, 300);
         SHAPE_NEAR_TOP:  rq.value = 32'hFFFF_FFFF - $urandom_range(0, 300);
         SHAPE_NEAR_SIGN: rq.value = $urandom_range(0, 1) ?
                                     32'h8000_0000 + $urandom_range(0, 300) :
                                     32'h7FFF_FFFF - $urandom_range(0, 300);
         default:         rq.value = '0;
      endcase
      rq.is_signed = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
         rq.radix = 5'($urandom_range(RADIX_MIN, RADIX_MAX));
      end else begin
         pick = $urandom_range(0, 16);
         rq.radix = (pick < 2) ? 5'(pick) : 5'(pick + 15);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         rq.min_width = 6'($urandom_range(0, 12));
      end else if (pick < 9) begin
         rq.min_width = 6'($urandom_range(13, 40));
      end else begin
         rq.min_width = 6'($urandom_range(41, 63));
      end
      return rq;
   endfunction

   // Request driver: presents queued items and predicts each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            spell_number(on_wire);
            items_taken++;
            offering = 1'b0;
            send_gap = draw_pause(send_calm);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (conv_backlog.size() > 0) begin
               on_wire = conv_backlog.pop_front();
               req_value     <= on_wire.value;
               req_is_signed <= on_wire.is_signed;
               req_radix     <= on_wire.radix;
               req_min_width <= on_wire.min_width;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // Response monitor: compares each character with the oldest one due.
   always @(posedge clock) begin
      text_char_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (text_due.size() == 0) begin
               $display("%t: unexpected item ch=%h last=%b bad_radix=%b",
                        $realtime, rsp_ch, rsp_last, rsp_bad_radix);
               fault_count++;
            end else begin
               due = text_due.pop_front();
               if (rsp_ch !== due.ch) begin
                  $display("%t: ch expected %h actual %h", $realtime, due.ch, rsp_ch);
                  fault_count++;
               end
               if (rsp_last !== due.last) begin
                  $display("%t: last expected %b actual %b", $realtime, due.last, rsp_last);
                  fault_count++;
               end
               if (rsp_bad_radix !== due.bad) begin
                  $display("%t: bad_radix expected %b actual %b",
                           $realtime, due.bad, rsp_bad_radix);
                  fault_count++;
               end
            end
            recv_gap = draw_pause(recv_calm);
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_ready <= (recv_gap == 0);
      end
   end

   initial begin
      int total;
      int i;

      // Directed: extremes, signs, zero fill, uppercase digits and bad bases.
      queue_request(32'd0,          1'b0, 5'd10, 6'd0);
      queue_request(32'd0,          1'b0, 5'd2,  6'd63);
      queue_request(32'd0,          1'b1, 5'd16, 6'd0);
      queue_request(32'hFFFF_FFFF,  1'b0, 5'd10, 6'd0);
      queue_request(32'hFFFF_FFFF,  1'b0, 5'd2,  6'd0);
      queue_request(32'hFFFF_FFFF,  1'b0, 5'd16, 6'd1);
      queue_request(32'hFFFF_FFFF,  1'b1, 5'd10, 6'd0);
      queue_request(32'h8000_0000,  1'b1, 5'd10, 6'd0);
      queue_request(32'h8000_0000,  1'b1, 5'd2,  6'd0);
      queue_request(32'h8000_0000,  1'b1, 5'd16, 6'd63);
      queue_request(32'h7FFF_FFFF,  1'b1, 5'd10, 6'd5);
      queue_request(32'h7FFF_FFFF,  1'b0, 5'd3,  6'd0);
      queue_request(32'h1234_5678,  1'b1, 5'd16, 6'd12);
      queue_request(32'hDEAD_BEEF,  1'b0, 5'd16, 6'd8);
      queue_request(32'h00AB_CDEF,  1'b0, 5'd15, 6'd0);
      queue_request(32'd255,        1'b0, 5'd8,  6'd4);
      queue_request(-32'sd42,       1'b1, 5'd7,  6'd0);
      queue_request(32'd100,        1'b0, 5'd0,  6'd3);
      queue_request(32'd100,        1'b1, 5'd1,  6'd63);
      queue_request(32'd100,        1'b0, 5'd17, 6'd0);
      queue_request(32'hFFFF_FFFF,  1'b1, 5'd31, 6'd63);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         conv_backlog.push_back(random_request());
      end
      total = conv_backlog.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < total) @(negedge clock);
      while (text_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fault_count == 0) begin
         $display("tb_integer_to_radix_string: clean");
      end else begin
         $display("tb_integer_to_radix_string: errors");
      end
      $finish;
   end

   // Watchdog on the cycle count.
   initial begin
      wait (cycles_run >= CYCLE_LIMIT);
      $display("tb_integer_to_radix_string: errors");
      $finish;
   end

endmodule
